[rtl/core/cec_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cec_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned COORD_W   = 24;
  localparam int unsigned RAD_W     = COORD_W - 2;
  localparam int unsigned MASS_W    = 16;
  localparam int unsigned THR_W     = 16;

  // square root unit: radicand and root widths
  localparam int unsigned SQ_IN_W  = 2 * COORD_W;
  localparam int unsigned SQ_OUT_W = COORD_W;

  // divider unit: numerator width is the quotient bits plus the denominator bits
  localparam int unsigned DIV_DEN_W = COORD_W;
  localparam int unsigned DIV_QUO_W = COORD_W + 4;
  localparam int unsigned DIV_NUM_W = DIV_QUO_W + DIV_DEN_W;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_vel_x;
    logic signed [COORD_W-1:0] first_vel_y;
    logic        [RAD_W-1:0]   first_radius;
    logic        [MASS_W-1:0]  first_mass;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_vel_x;
    logic signed [COORD_W-1:0] second_vel_y;
    logic        [RAD_W-1:0]   second_radius;
    logic        [MASS_W-1:0]  second_mass;
  } cmd_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] new_first_x;
    logic signed [COORD_W-1:0] new_first_y;
    logic signed [COORD_W-1:0] new_first_vel_x;
    logic signed [COORD_W-1:0] new_first_vel_y;
    logic signed [COORD_W-1:0] new_second_vel_x;
    logic signed [COORD_W-1:0] new_second_vel_y;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/circle_elastic_collision_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  ports                     transaction
// command   in         start, busy, cmd_i        start high and busy low at a clock edge
// result    out        done_o, res_o             done_o high for one cycle, always taken
// config    in         cfg_we_i, cfg_wdata_i     cfg_we_i high at a clock edge
//
// one pair enters per cycle; each result passes through the 24-stage square root and
// then the three 28-stage dividers in series. busy stays low, since the pipeline
// never stalls.
// rst_ni clears the valid bits and sets thr_q to 1.0; there is no
// clearing pass.
module circle_elastic_collision_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  cec_pkg::cmd_t               cmd_i,
  input  logic                        cfg_we_i,
  input  logic [cec_pkg::THR_W-1:0]   cfg_wdata_i,
  output logic                        done_o,
  output cec_pkg::res_t               res_o
);

  localparam int unsigned CW  = cec_pkg::COORD_W;
  localparam int unsigned RW  = cec_pkg::RAD_W;
  localparam int unsigned MW  = cec_pkg::MASS_W;
  localparam int unsigned TW  = cec_pkg::THR_W;
  localparam int unsigned DFW = CW + 1;
  localparam int unsigned SMW = RW + 1;
  localparam int unsigned MSW = MW + 1;
  localparam int unsigned SQW = 2 * DFW;
  localparam int unsigned D2W = SQW + 1;
  localparam int unsigned RRW = 2 * SMW;
  localparam int unsigned EXW = SMW + DFW;
  localparam int unsigned NW  = cec_pkg::DIV_NUM_W;
  localparam int unsigned QW  = cec_pkg::DIV_QUO_W;
  localparam int unsigned DW  = cec_pkg::DIV_DEN_W;
  localparam int unsigned LW  = cec_pkg::SQ_OUT_W;
  localparam int unsigned SQD = cec_pkg::SQ_OUT_W;
  localparam int unsigned JW  = MW + QW + 1;
  localparam int unsigned EW  = QW + 2;
  localparam int unsigned LAT = 9 + SQD + 3 * QW;

  typedef struct packed {
    cec_pkg::cmd_t  inp;
    logic           cx_neg;
    logic           cy_neg;
    logic [CW-1:0]  cx_mag;
    logic [CW-1:0]  cy_mag;
    logic [SMW-1:0] dsum;
    logic [RW-1:0]  rmax;
    logic [MSW-1:0] msum;
    logic           apart;
    logic           zero;
    logic           dot_neg;
    logic           push;
    logic [LW-1:0]  lc;
    logic [CW-1:0]  new_x;
    logic [CW-1:0]  new_y;
  } ctx_t;

  typedef struct packed {
    ctx_t           ctx;
    logic [D2W-1:0] dmag;
    logic [EXW-1:0] exm;
    logic [EXW-1:0] eym;
  } sq_ctx_t;

  function automatic logic [EW-1:0] sx(input logic [CW-1:0] v);
    return {{(EW-CW){v[CW-1]}}, v};
  endfunction

  function automatic logic [CW-1:0] sat_fn(input logic [EW-1:0] v);
    logic [CW-1:0] res;
    if (!v[EW-1] && (|v[EW-2:CW-1])) begin
      res = {1'b0, {(CW-1){1'b1}}};
    end else if (v[EW-1] && !(&v[EW-2:CW-1])) begin
      res = {1'b1, {(CW-1){1'b0}}};
    end else begin
      res = v[CW-1:0];
    end
    return res;
  endfunction

  logic [TW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= cec_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign busy = 1'b0;

  // stage a: differences, magnitudes and sums
  logic signed [DFW-1:0] x1e, y1e, x2e, y2e, v1xe, v1ye, v2xe, v2ye;
  logic signed [DFW-1:0] cx_d, cy_d;
  logic                  cx_neg_d, cy_neg_d;
  ctx_t                  a_ctx_d;

  assign x1e  = {cmd_i.first_x[CW-1], cmd_i.first_x};
  assign y1e  = {cmd_i.first_y[CW-1], cmd_i.first_y};
  assign x2e  = {cmd_i.second_x[CW-1], cmd_i.second_x};
  assign y2e  = {cmd_i.second_y[CW-1], cmd_i.second_y};
  assign v1xe = {cmd_i.first_vel_x[CW-1], cmd_i.first_vel_x};
  assign v1ye = {cmd_i.first_vel_y[CW-1], cmd_i.first_vel_y};
  assign v2xe = {cmd_i.second_vel_x[CW-1], cmd_i.second_vel_x};
  assign v2ye = {cmd_i.second_vel_y[CW-1], cmd_i.second_vel_y};
  assign cx_d = x2e - x1e;
  assign cy_d = y2e - y1e;
  assign cx_neg_d = x2e < x1e;
  assign cy_neg_d = y2e < y1e;

  always_comb begin
    a_ctx_d        = '0;
    a_ctx_d.inp    = cmd_i;
    a_ctx_d.cx_neg = cx_neg_d;
    a_ctx_d.cy_neg = cy_neg_d;
    a_ctx_d.dsum   = SMW'(cmd_i.first_radius) + SMW'(cmd_i.second_radius);
    a_ctx_d.rmax   = (cmd_i.first_radius > cmd_i.second_radius) ?
                     cmd_i.first_radius : cmd_i.second_radius;
    a_ctx_d.msum   = MSW'(cmd_i.first_mass) + MSW'(cmd_i.second_mass);
  end

  logic                  a_vld_q;
  ctx_t                  a_ctx_q;
  logic signed [DFW-1:0] a_cx_q, a_cy_q, a_dvx_q, a_dvy_q;
  logic [DFW-1:0]        a_cxm_q, a_cym_q;

  always_ff @(posedge clk_i) begin
    a_ctx_q <= a_ctx_d;
    a_cx_q  <= cx_d;
    a_cy_q  <= cy_d;
    a_cxm_q <= cx_neg_d ? DFW'(x1e - x2e) : DFW'(cx_d);
    a_cym_q <= cy_neg_d ? DFW'(y1e - y2e) : DFW'(cy_d);
    a_dvx_q <= v1xe - v2xe;
    a_dvy_q <= v1ye - v2ye;
  end

  // stage b: squares and products
  logic                  b_vld_q;
  ctx_t                  b_ctx_q, b_ctx_d;
  logic [SQW-1:0]        b_sqx_q, b_sqy_q;
  logic [RRW-1:0]        b_rr_q;
  logic signed [SQW-1:0] b_px_q, b_py_q;
  logic [EXW-1:0]        b_exm_q, b_eym_q;

  always_comb begin
    b_ctx_d        = a_ctx_q;
    b_ctx_d.cx_mag = a_cxm_q[CW-1:0];
    b_ctx_d.cy_mag = a_cym_q[CW-1:0];
  end

  always_ff @(posedge clk_i) begin
    b_ctx_q <= b_ctx_d;
    b_sqx_q <= SQW'(a_cxm_q) * SQW'(a_cxm_q);
    b_sqy_q <= SQW'(a_cym_q) * SQW'(a_cym_q);
    b_rr_q  <= RRW'(a_ctx_q.dsum) * RRW'(a_ctx_q.dsum);
    b_px_q  <= a_dvx_q * a_cx_q;
    b_py_q  <= a_dvy_q * a_cy_q;
    b_exm_q <= EXW'(a_ctx_q.dsum) * EXW'(a_cxm_q);
    b_eym_q <= EXW'(a_ctx_q.dsum) * EXW'(a_cym_q);
  end

  // stage c: squared distance, contact test and dot product
  logic [D2W-1:0] d2_sum, dot_sum;
  ctx_t           c_ctx_d;

  assign d2_sum  = D2W'(b_sqx_q) + D2W'(b_sqy_q);
  assign dot_sum = {b_px_q[SQW-1], b_px_q} + {b_py_q[SQW-1], b_py_q};

  always_comb begin
    c_ctx_d         = b_ctx_q;
    c_ctx_d.apart   = d2_sum > D2W'(b_rr_q);
    c_ctx_d.zero    = d2_sum == '0;
    c_ctx_d.dot_neg = dot_sum[D2W-1];
  end

  logic           c_vld_q;
  ctx_t           c_ctx_q;
  logic [D2W-1:0] c_d2_q, c_dot_q;
  logic [EXW-1:0] c_exm_q, c_eym_q;

  always_ff @(posedge clk_i) begin
    c_ctx_q <= c_ctx_d;
    c_d2_q  <= d2_sum;
    c_dot_q <= dot_sum;
    c_exm_q <= b_exm_q;
    c_eym_q <= b_eym_q;
  end

  // square root of the squared distance, context runs alongside
  logic [LW-1:0] root;
  sq_ctx_t       l1_in;
  sq_ctx_t       l1_q [SQD];
  logic [SQD-1:0] v1_q;

  cec_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (c_d2_q[cec_pkg::SQ_IN_W-1:0]),
    .root_o (root)
  );

  always_comb begin
    l1_in.ctx  = c_ctx_q;
    l1_in.dmag = c_dot_q[D2W-1] ? D2W'(-c_dot_q) : c_dot_q;
    l1_in.exm  = c_exm_q;
    l1_in.eym  = c_eym_q;
  end

  always_ff @(posedge clk_i) begin
    l1_q[0] <= l1_in;
    for (int k = 1; k < SQD; k++) begin
      l1_q[k] <= l1_q[k-1];
    end
  end

  // stage d: push-out test and first divisions by the centre distance
  logic signed [CW:0] pen;
  ctx_t               d_ctx_d;

  assign pen = $signed((CW+1)'(l1_q[SQD-1].ctx.dsum)) - $signed((CW+1)'(root));

  always_comb begin
    d_ctx_d      = l1_q[SQD-1].ctx;
    d_ctx_d.lc   = root;
    d_ctx_d.push = !d_ctx_d.apart && !d_ctx_d.zero &&
                   (pen > $signed((CW+1)'(thr_q)));
  end

  logic          d_vld_q;
  ctx_t          d_ctx_q;
  logic [NW-1:0] d_nx_q, d_ny_q, d_ns_q;

  always_ff @(posedge clk_i) begin
    d_ctx_q <= d_ctx_d;
    d_nx_q  <= NW'(l1_q[SQD-1].exm) + NW'(root >> 1);
    d_ny_q  <= NW'(l1_q[SQD-1].eym) + NW'(root >> 1);
    d_ns_q  <= NW'(l1_q[SQD-1].dmag) + NW'(root >> 1);
  end

  logic [QW-1:0] qx, qy, qs;

  cec_div u_div_px (.clk_i(clk_i), .num_i(d_nx_q), .den_i(DW'(d_ctx_q.lc)), .quo_o(qx));
  cec_div u_div_py (.clk_i(clk_i), .num_i(d_ny_q), .den_i(DW'(d_ctx_q.lc)), .quo_o(qy));
  cec_div u_div_s  (.clk_i(clk_i), .num_i(d_ns_q), .den_i(DW'(d_ctx_q.lc)), .quo_o(qs));

  ctx_t          l2_q [QW];
  logic [QW-1:0] v2_q;

  always_ff @(posedge clk_i) begin
    l2_q[0] <= d_ctx_q;
    for (int k = 1; k < QW; k++) begin
      l2_q[k] <= l2_q[k-1];
    end
  end

  // stage e: pushed-out centre
  logic [EW-1:0] px_sum, py_sum;
  ctx_t          e_ctx_d;
  ctx_t          c2;

  assign c2     = l2_q[QW-1];
  assign px_sum = c2.cx_neg ? sx(c2.inp.second_x) + EW'(qx) : sx(c2.inp.second_x) - EW'(qx);
  assign py_sum = c2.cy_neg ? sx(c2.inp.second_y) + EW'(qy) : sx(c2.inp.second_y) - EW'(qy);

  always_comb begin
    e_ctx_d       = c2;
    e_ctx_d.new_x = c2.push ? sat_fn(px_sum) : c2.inp.first_x;
    e_ctx_d.new_y = c2.push ? sat_fn(py_sum) : c2.inp.first_y;
  end

  logic          e_vld_q;
  ctx_t          e_ctx_q;
  logic [QW-1:0] e_qs_q;

  always_ff @(posedge clk_i) begin
    e_ctx_q <= e_ctx_d;
    e_qs_q  <= qs;
  end

  // stage f: impulse numerators, magnitude only, sign follows the dot product
  logic          f_vld_q;
  ctx_t          f_ctx_q;
  logic [JW-1:0] f_j1_q, f_j2_q;

  always_ff @(posedge clk_i) begin
    f_ctx_q <= e_ctx_q;
    f_j1_q  <= JW'({e_ctx_q.inp.second_mass, 1'b0}) * JW'(e_qs_q);
    f_j2_q  <= JW'({e_ctx_q.inp.first_mass, 1'b0}) * JW'(e_qs_q);
  end

  // stage g: rounding offset for the division by the mass sum
  logic          g_vld_q;
  ctx_t          g_ctx_q;
  logic [NW-1:0] g_n1_q, g_n2_q;

  always_ff @(posedge clk_i) begin
    g_ctx_q <= f_ctx_q;
    g_n1_q  <= NW'(f_j1_q) + NW'(f_ctx_q.msum >> 1);
    g_n2_q  <= NW'(f_j2_q) + NW'(f_ctx_q.msum >> 1);
  end

  logic [QW-1:0] qj1, qj2;

  cec_div u_div_j1 (.clk_i(clk_i), .num_i(g_n1_q), .den_i(DW'(g_ctx_q.msum)), .quo_o(qj1));
  cec_div u_div_j2 (.clk_i(clk_i), .num_i(g_n2_q), .den_i(DW'(g_ctx_q.msum)), .quo_o(qj2));

  ctx_t          l3_q [QW];
  logic [QW-1:0] v3_q;

  always_ff @(posedge clk_i) begin
    l3_q[0] <= g_ctx_q;
    for (int k = 1; k < QW; k++) begin
      l3_q[k] <= l3_q[k-1];
    end
  end

  // stage h: impulse times centre vector
  logic          h_vld_q;
  ctx_t          h_ctx_q;
  logic [NW-1:0] h_p1x_q, h_p1y_q, h_p2x_q, h_p2y_q;

  always_ff @(posedge clk_i) begin
    h_ctx_q <= l3_q[QW-1];
    h_p1x_q <= NW'(qj1) * NW'(l3_q[QW-1].cx_mag);
    h_p1y_q <= NW'(qj1) * NW'(l3_q[QW-1].cy_mag);
    h_p2x_q <= NW'(qj2) * NW'(l3_q[QW-1].cx_mag);
    h_p2y_q <= NW'(qj2) * NW'(l3_q[QW-1].cy_mag);
  end

  // stage i: rounding offset for the division by the centre distance
  logic          i_vld_q;
  ctx_t          i_ctx_q;
  logic [NW-1:0] i_n1x_q, i_n1y_q, i_n2x_q, i_n2y_q;

  always_ff @(posedge clk_i) begin
    i_ctx_q <= h_ctx_q;
    i_n1x_q <= h_p1x_q + NW'(h_ctx_q.lc >> 1);
    i_n1y_q <= h_p1y_q + NW'(h_ctx_q.lc >> 1);
    i_n2x_q <= h_p2x_q + NW'(h_ctx_q.lc >> 1);
    i_n2y_q <= h_p2y_q + NW'(h_ctx_q.lc >> 1);
  end

  logic [QW-1:0] t1x, t1y, t2x, t2y;

  cec_div u_div_t1x (.clk_i(clk_i), .num_i(i_n1x_q), .den_i(DW'(i_ctx_q.lc)), .quo_o(t1x));
  cec_div u_div_t1y (.clk_i(clk_i), .num_i(i_n1y_q), .den_i(DW'(i_ctx_q.lc)), .quo_o(t1y));
  cec_div u_div_t2x (.clk_i(clk_i), .num_i(i_n2x_q), .den_i(DW'(i_ctx_q.lc)), .quo_o(t2x));
  cec_div u_div_t2y (.clk_i(clk_i), .num_i(i_n2y_q), .den_i(DW'(i_ctx_q.lc)), .quo_o(t2y));

  ctx_t          l4_q [QW];
  logic [QW-1:0] v4_q;

  always_ff @(posedge clk_i) begin
    l4_q[0] <= i_ctx_q;
    for (int k = 1; k < QW; k++) begin
      l4_q[k] <= l4_q[k-1];
    end
  end

  // stage j: velocity update and result selection
  ctx_t          c4;
  logic          neg_x, neg_y;
  logic [EW-1:0] n1x, n1y, n2x, n2y, nudge_y;
  cec_pkg::res_t res_d;

  assign c4      = l4_q[QW-1];
  assign neg_x   = c4.dot_neg ^ c4.cx_neg;
  assign neg_y   = c4.dot_neg ^ c4.cy_neg;
  assign n1x     = neg_x ? sx(c4.inp.first_vel_x) + EW'(t1x) : sx(c4.inp.first_vel_x) - EW'(t1x);
  assign n1y     = neg_y ? sx(c4.inp.first_vel_y) + EW'(t1y) : sx(c4.inp.first_vel_y) - EW'(t1y);
  assign n2x     = neg_x ? sx(c4.inp.second_vel_x) - EW'(t2x) :
                           sx(c4.inp.second_vel_x) + EW'(t2x);
  assign n2y     = neg_y ? sx(c4.inp.second_vel_y) - EW'(t2y) :
                           sx(c4.inp.second_vel_y) + EW'(t2y);
  assign nudge_y = sx(c4.inp.first_y) + EW'(c4.rmax);

  always_comb begin
    res_d.hit              = 1'b0;
    res_d.new_first_x      = c4.inp.first_x;
    res_d.new_first_y      = c4.inp.first_y;
    res_d.new_first_vel_x  = c4.inp.first_vel_x;
    res_d.new_first_vel_y  = c4.inp.first_vel_y;
    res_d.new_second_vel_x = c4.inp.second_vel_x;
    res_d.new_second_vel_y = c4.inp.second_vel_y;
    if (c4.apart) begin
      res_d.hit = 1'b0;
    end else if (c4.zero) begin
      // coincident centres: nudge the first circle up
      res_d.hit         = 1'b1;
      res_d.new_first_y = sat_fn(nudge_y);
    end else begin
      res_d.new_first_x = c4.new_x;
      res_d.new_first_y = c4.new_y;
      if (!c4.dot_neg) begin
        res_d.hit = 1'b1;
        if (c4.msum != '0) begin
          res_d.new_first_vel_x  = sat_fn(n1x);
          res_d.new_first_vel_y  = sat_fn(n1y);
          res_d.new_second_vel_x = sat_fn(n2x);
          res_d.new_second_vel_y = sat_fn(n2y);
        end
      end
    end
  end

  logic          done_q;
  cec_pkg::res_t res_q;

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      v1_q    <= '0;
      d_vld_q <= 1'b0;
      v2_q    <= '0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      v3_q    <= '0;
      h_vld_q <= 1'b0;
      i_vld_q <= 1'b0;
      v4_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      a_vld_q <= start && !busy;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      v1_q    <= {v1_q[SQD-2:0], c_vld_q};
      d_vld_q <= v1_q[SQD-1];
      v2_q    <= {v2_q[QW-2:0], d_vld_q};
      e_vld_q <= v2_q[QW-1];
      f_vld_q <= e_vld_q;
      g_vld_q <= f_vld_q;
      v3_q    <= {v3_q[QW-2:0], g_vld_q};
      h_vld_q <= v3_q[QW-1];
      i_vld_q <= h_vld_q;
      v4_q    <= {v4_q[QW-2:0], i_vld_q};
      done_q  <= v4_q[QW-1];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef NO_ASSERTIONS
  // every accepted transaction comes out after the fixed pipeline latency
  assert property (@(posedge clk_i) disable iff (!rst_ni) a_vld_q |-> ##LAT done_o)
    else $error("transaction lost in the pipeline");

  // no result appears without a matching transaction that entered the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(a_vld_q, LAT))
    else $error("result strobe without a matching transaction");
`endif

endmodule

`default_nettype wire

[rtl/core/cec_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

module cec_sqrt (
  input  logic                          clk_i,
  input  logic [cec_pkg::SQ_IN_W-1:0]   rad_i,
  output logic [cec_pkg::SQ_OUT_W-1:0]  root_o
);

  localparam int unsigned IW  = cec_pkg::SQ_IN_W;
  localparam int unsigned N   = cec_pkg::SQ_OUT_W;
  localparam int unsigned RMW = N + 2;

  logic [RMW-1:0] rem_q  [N];
  logic [N-1:0]   root_q [N];
  logic [IW-1:0]  rad_q  [N];

  logic [RMW-1:0] rem_s  [N];
  logic [N-1:0]   root_s [N];
  logic [IW-1:0]  rad_s  [N];

  logic [RMW+1:0] acc    [N];
  logic [RMW+1:0] trial  [N];
  logic [RMW-1:0] rem_d  [N];
  logic [N-1:0]   root_d [N];
  logic [IW-1:0]  rad_d  [N];

  // one root bit per stage, two radicand bits brought down each time
  for (genvar k = 0; k < N; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign rem_s[k]  = '0;
      assign root_s[k] = '0;
      assign rad_s[k]  = rad_i;
    end else begin : g_next
      assign rem_s[k]  = rem_q[k-1];
      assign root_s[k] = root_q[k-1];
      assign rad_s[k]  = rad_q[k-1];
    end

    always_comb begin
      acc[k]   = {rem_s[k], rad_s[k][IW-1 -: 2]};
      trial[k] = (RMW+2)'({root_s[k], 2'b01});
      if (acc[k] >= trial[k]) begin
        rem_d[k]  = RMW'(acc[k] - trial[k]);
        root_d[k] = {root_s[k][N-2:0], 1'b1};
      end else begin
        rem_d[k]  = acc[k][RMW-1:0];
        root_d[k] = {root_s[k][N-2:0], 1'b0};
      end
      rad_d[k] = {rad_s[k][IW-3:0], 2'b00};
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
      rad_q[k]  <= rad_d[k];
    end
  end

  assign root_o = root_q[N-1];

endmodule

`default_nettype wire

[rtl/core/cec_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module cec_div (
  input  logic                           clk_i,
  input  logic [cec_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [cec_pkg::DIV_DEN_W-1:0]  den_i,
  output logic [cec_pkg::DIV_QUO_W-1:0]  quo_o
);

  localparam int unsigned NW = cec_pkg::DIV_NUM_W;
  localparam int unsigned QW = cec_pkg::DIV_QUO_W;
  localparam int unsigned DW = cec_pkg::DIV_DEN_W;

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] den_q [QW];

  logic [DW-1:0] rem_s [QW];
  logic [QW-1:0] low_s [QW];
  logic [QW-1:0] quo_s [QW];
  logic [DW-1:0] den_s [QW];

  logic [DW:0]   acc   [QW];
  logic [DW-1:0] rem_d [QW];
  logic [QW-1:0] quo_d [QW];

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign rem_s[k] = num_i[NW-1:QW];
      assign low_s[k] = num_i[QW-1:0];
      assign quo_s[k] = '0;
      assign den_s[k] = den_i;
    end else begin : g_next
      assign rem_s[k] = rem_q[k-1];
      assign low_s[k] = low_q[k-1];
      assign quo_s[k] = quo_q[k-1];
      assign den_s[k] = den_q[k-1];
    end

    always_comb begin
      acc[k] = {rem_s[k], low_s[k][QW-1]};
      if (acc[k] >= {1'b0, den_s[k]}) begin
        rem_d[k] = DW'(acc[k] - {1'b0, den_s[k]});
        quo_d[k] = {quo_s[k][QW-2:0], 1'b1};
      end else begin
        rem_d[k] = acc[k][DW-1:0];
        quo_d[k] = {quo_s[k][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d[k];
      low_q[k] <= {low_s[k][QW-2:0], 1'b0};
      quo_q[k] <= quo_d[k];
      den_q[k] <= den_s[k];
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

`default_nettype wire
